FILE: sv/tnlc_pkg.sv
// ----------------------------------------------------------------------------
// tnlc_pkg
// Shared types and constants for the TTL name lookup cache.
// ----------------------------------------------------------------------------
package tnlc_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] TTL_RESET = 32'd1000;
  localparam int          LEN_W     = 8;
  localparam int          Q_DEPTH   = 2;

  // bypass words, bit 5 forced high on every byte, first character in the top byte
  localparam logic [127:0] NEEDLE_A = 128'h73656c6563747f636861726163746572;
  localparam logic [111:0] NEEDLE_B = 112'h6d616b657f636861726163746572;

  localparam logic REG_LOOKUP_ENABLE = 1'b0;
  localparam logic REG_TTL_MS        = 1'b1;

  typedef enum logic {
    JOB_LOOKUP = 1'b0,
    JOB_FILL   = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              eligible;
    logic [31:0]       hash;
    logic [LEN_W-1:0]  len;
    logic [31:0]       now_ms;
    logic [31:0]       fill_handle;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic [31:0]       hash;
    logic [31:0]       handle;
    logic [31:0]       stamp;
    logic [LEN_W-1:0]  len;
  } meta_t;

  typedef struct packed {
    logic idle;
    logic q_empty;
    logic q_full;
  } back_status_t;

endpackage

FILE: sv/tnlc_ram.sv
// ----------------------------------------------------------------------------
// tnlc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tnlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tnlc_queue.sv
// ----------------------------------------------------------------------------
// tnlc_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tnlc_queue
  import tnlc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic nonempty,
  output logic full
);

  localparam int PW = $clog2(Q_DEPTH);

  job_t         slots [Q_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW:0]   count;

  assign dout     = slots[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == (PW+1)'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: sv/tnlc_front.sv
// ----------------------------------------------------------------------------
// tnlc_front
// Front end: hashes name bytes, tracks bypass words, buffers the key and
// queues lookup and fill jobs.
// ----------------------------------------------------------------------------
module tnlc_front
  import tnlc_pkg::*;
#(
  parameter int KEY_BYTES = 160
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 cmd,
  input  logic [7:0]           name_byte,
  input  logic                 last_byte,
  input  logic [31:0]          now_ms,
  input  logic [31:0]          fill_handle,
  input  back_status_t         status,
  output logic                 q_push,
  output job_t                 q_job,
  output logic                 clear_pending,
  output logic                 nb_we,
  output logic [$clog2((KEY_BYTES+7)/8)-1:0] nb_waddr,
  output logic [63:0]          nb_wdata
);

  localparam int NB_WORDS = (KEY_BYTES + 7) / 8;
  localparam int NB_AW    = $clog2(NB_WORDS);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEY_BYTES - 1);

  logic [31:0]      hash, hash_next;
  logic [LEN_W-1:0] len, len_next;
  logic             too_long, too_long_next;
  logic [127:0]     window, window_next;
  logic             bypass, bypass_next;
  logic [63:0]      acc, acc_next;
  logic             accept, absorb, eligible;
  logic [31:0]      mixed;

  assign item_stall = cmd ? status.q_full : !(status.idle && status.q_empty);
  assign accept     = item_valid && !item_stall;
  assign absorb     = accept && !cmd && (name_byte != 8'd0) && !too_long
                      && (len < LEN_MAX);
  assign mixed      = hash ^ {24'd0, name_byte};

  always_comb begin
    hash_next     = hash;
    len_next      = len;
    too_long_next = too_long;
    window_next   = window;
    bypass_next   = bypass;
    acc_next      = acc;
    if (accept && !cmd && name_byte != 8'd0 && !too_long) begin
      if (len >= LEN_MAX) begin
        too_long_next = 1'b1;
      end else begin
        hash_next   = mixed * FNV_PRIME;
        len_next    = len + 1'b1;
        window_next = {window[119:0], name_byte | 8'h20};
        acc_next[{len[2:0], 3'b000} +: 8] = name_byte;
        if (window_next == NEEDLE_A || window_next[111:0] == NEEDLE_B) begin
          bypass_next = 1'b1;
        end
      end
    end
  end

  assign eligible = !too_long_next && (len_next != '0) && (hash_next != '0) && !bypass_next;

  assign nb_we    = absorb;
  assign nb_waddr = NB_AW'(len >> 3);
  assign nb_wdata = acc_next;

  assign clear_pending = accept && !cmd;

  always_comb begin
    q_job.kind        = cmd ? JOB_FILL : JOB_LOOKUP;
    q_job.eligible    = eligible;
    q_job.hash        = hash_next;
    q_job.len         = len_next;
    q_job.now_ms      = now_ms;
    q_job.fill_handle = fill_handle;
    q_push            = accept && (cmd || last_byte);
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash     <= FNV_BASIS;
      len      <= '0;
      too_long <= 1'b0;
      window   <= '0;
      bypass   <= 1'b0;
    end else if (accept && !cmd && last_byte) begin
      hash     <= FNV_BASIS;
      len      <= '0;
      too_long <= 1'b0;
      window   <= '0;
      bypass   <= 1'b0;
    end else begin
      hash     <= hash_next;
      len      <= len_next;
      too_long <= too_long_next;
      window   <= window_next;
      bypass   <= bypass_next;
    end
  end

endmodule

FILE: sv/tnlc_back.sv
// ----------------------------------------------------------------------------
// tnlc_back
// Back end: slot lookup, key compare, fill of the slot, result register.
// ----------------------------------------------------------------------------
module tnlc_back
  import tnlc_pkg::*;
#(
  parameter int SLOTS     = 4096,
  parameter int KEY_BYTES = 160
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 lookup_enable,
  input  logic [31:0]          ttl_ms,
  input  logic                 q_nonempty,
  input  job_t                 q_job,
  output logic                 q_pop,
  input  logic                 clear_pending,
  output logic                 idle,
  output logic                 meta_we,
  output logic [$clog2(SLOTS)-1:0] meta_waddr,
  output meta_t                meta_wdata,
  output logic [$clog2(SLOTS)-1:0] meta_raddr,
  input  meta_t                meta_rdata,
  output logic [$clog2((KEY_BYTES+7)/8)-1:0] nb_raddr,
  input  logic [63:0]          nb_rdata,
  output logic                 txt_we,
  output logic [$clog2(SLOTS*((KEY_BYTES+7)/8))-1:0] txt_waddr,
  output logic [63:0]          txt_wdata,
  output logic [$clog2(SLOTS*((KEY_BYTES+7)/8))-1:0] txt_raddr,
  input  logic [63:0]          txt_rdata,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 hit,
  output logic [31:0]          handle,
  output logic                 cacheable
);

  localparam int NB_WORDS = (KEY_BYTES + 7) / 8;
  localparam int NB_AW    = $clog2(NB_WORDS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int TXT_AW   = $clog2(SLOTS * NB_WORDS);

  typedef enum logic [7:0] {
    B_CLEAR   = 8'b0000_0001,
    B_IDLE    = 8'b0000_0010,
    B_META    = 8'b0000_0100,
    B_CMP_RD  = 8'b0000_1000,
    B_CMP_CHK = 8'b0001_0000,
    B_DONE    = 8'b0010_0000,
    B_CP_RD   = 8'b0100_0000,
    B_CP_WR   = 8'b1000_0000
  } bstate_t;

  bstate_t          st;
  logic [SLOT_W-1:0] clr_cnt;
  job_t             cur;
  logic [NB_AW-1:0] w;
  logic [TXT_AW-1:0] base;
  logic             res_hit;
  logic [31:0]      res_handle;
  logic             pend_valid;
  logic [31:0]      pend_hash;
  logic [LEN_W-1:0] pend_len;
  logic [NB_AW-1:0] last_w;
  logic [LEN_W-1:0] rem;
  logic [63:0]      byte_mask;
  logic             cand, words_eq, out_free, do_fill;
  logic [31:0]      age;

  assign idle     = (st == B_IDLE);
  assign out_free = !result_valid || !result_stall;
  assign q_pop    = (st == B_IDLE) && q_nonempty;
  assign do_fill  = pend_valid && (q_job.fill_handle != '0);
  assign last_w   = NB_AW'((cur.len - 1'b1) >> 3);
  assign age      = cur.now_ms - meta_rdata.stamp;

  assign cand = cur.eligible && lookup_enable && meta_rdata.valid
                && (meta_rdata.hash == cur.hash) && (age < ttl_ms)
                && (meta_rdata.len == cur.len);

  // bytes past the key end in the last word are don't-care
  always_comb begin
    rem = cur.len - {w, 3'b000};
    for (int k = 0; k < 8; k++) begin
      byte_mask[8*k +: 8] = (LEN_W'(k) < rem) ? 8'hff : 8'h00;
    end
  end
  assign words_eq = ((nb_rdata ^ txt_rdata) & byte_mask) == '0;

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = clr_cnt;
    meta_wdata = '0;
    if (st == B_CLEAR) begin
      meta_we = 1'b1;
    end else if (q_pop && q_job.kind == JOB_FILL && do_fill) begin
      meta_we           = 1'b1;
      meta_waddr        = pend_hash[SLOT_W-1:0];
      meta_wdata.valid  = 1'b1;
      meta_wdata.hash   = pend_hash;
      meta_wdata.handle = q_job.fill_handle;
      meta_wdata.stamp  = q_job.now_ms;
      meta_wdata.len    = pend_len;
    end
  end

  assign meta_raddr = q_job.hash[SLOT_W-1:0];
  assign nb_raddr   = w;
  assign txt_raddr  = base + TXT_AW'(w);
  assign txt_we     = (st == B_CP_WR);
  assign txt_waddr  = base + TXT_AW'(w);
  assign txt_wdata  = nb_rdata;

  always_ff @(posedge clk) begin
    case (st)
      B_IDLE: begin
        if (q_pop) begin
          w <= '0;
          if (q_job.kind == JOB_FILL) begin
            cur.len <= pend_len;
            base    <= TXT_AW'(pend_hash[SLOT_W-1:0]) * TXT_AW'(NB_WORDS);
          end else begin
            cur <= q_job;
          end
        end
      end
      B_META: begin
        res_handle <= meta_rdata.handle;
        res_hit    <= 1'b0;
        base       <= TXT_AW'(cur.hash[SLOT_W-1:0]) * TXT_AW'(NB_WORDS);
      end
      B_CMP_CHK: begin
        if (words_eq && w == last_w) begin
          res_hit <= 1'b1;
        end
        w <= w + 1'b1;
      end
      B_CP_WR: begin
        w <= w + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= B_CLEAR;
      clr_cnt      <= '0;
      pend_valid   <= 1'b0;
      pend_hash    <= '0;
      pend_len     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && st != B_DONE) begin
        result_valid <= 1'b0;
      end
      if (clear_pending) begin
        pend_valid <= 1'b0;
      end
      case (st)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SLOT_W'(SLOTS - 1)) begin
            st <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            if (q_job.kind == JOB_FILL) begin
              pend_valid <= 1'b0;
              if (do_fill) begin
                st <= B_CP_RD;
              end
            end else begin
              st <= B_META;
            end
          end
        end
        B_META: begin
          st <= cand ? B_CMP_RD : B_DONE;
        end
        B_CMP_RD: begin
          st <= B_CMP_CHK;
        end
        B_CMP_CHK: begin
          if (!words_eq || w == last_w) begin
            st <= B_DONE;
          end else begin
            st <= B_CMP_RD;
          end
        end
        B_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            hit          <= res_hit;
            handle       <= res_hit ? res_handle : 32'd0;
            cacheable    <= cur.eligible && !res_hit;
            pend_valid   <= cur.eligible && !res_hit;
            pend_hash    <= cur.hash;
            pend_len     <= cur.len;
            st           <= B_IDLE;
          end
        end
        B_CP_RD: begin
          st <= B_CP_WR;
        end
        B_CP_WR: begin
          st <= (w == last_w) ? B_IDLE : B_CP_RD;
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ttl_name_lookup_cache_core.sv
// ----------------------------------------------------------------------------
// ttl_name_lookup_cache_core
// Direct-mapped cache of handles keyed by FNV-1a hashed names, with TTL.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | word
//  ---------+------------------------------------------------+-------------------
//  item     | item_valid, item_stall                         | cmd, name_byte,
//           |                                                | last_byte, now_ms,
//           |                                                | fill_handle
//  result   | result_valid, result_stall                     | hit, handle,
//           |                                                | cacheable
//  config   | cfg_write, cfg_index, cfg_data                 | register write
//
// Name bytes are taken one per cycle. A last byte queues a lookup: a slot read,
// then a read and a check state per compared 8-byte key word, then a load of
// the result register. A fill reads and writes back each copied key word.
// Name bytes stall while the back end works or a job is queued; fills queue (2 deep).
// After reset the slot table is cleared slot by slot before names are taken.
module ttl_name_lookup_cache_core
  import tnlc_pkg::*;
#(
  parameter int SLOTS     = 4096,
  parameter int KEY_BYTES = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        cmd,
  input  logic [7:0]  name_byte,
  input  logic        last_byte,
  input  logic [31:0] now_ms,
  input  logic [31:0] fill_handle,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        hit,
  output logic [31:0] handle,
  output logic        cacheable
);

  localparam int NB_WORDS = (KEY_BYTES + 7) / 8;
  localparam int NB_AW    = $clog2(NB_WORDS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int TXT_D    = SLOTS * NB_WORDS;
  localparam int TXT_AW   = $clog2(TXT_D);

  logic         lookup_enable;
  logic [31:0]  ttl_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_enable <= 1'b0;
      ttl_ms        <= TTL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOOKUP_ENABLE: lookup_enable <= cfg_data[0];
        REG_TTL_MS:        ttl_ms        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  back_status_t      status;
  job_t              q_in, q_out;
  logic              q_push, q_pop, q_nonempty, q_full, clear_pending, back_idle;
  logic              nb_we;
  logic [NB_AW-1:0]  nb_waddr, nb_raddr;
  logic [63:0]       nb_wdata, nb_rdata;
  logic              meta_we;
  logic [SLOT_W-1:0] meta_waddr, meta_raddr;
  meta_t             meta_wdata, meta_rdata;
  logic              txt_we;
  logic [TXT_AW-1:0] txt_waddr, txt_raddr;
  logic [63:0]       txt_wdata, txt_rdata;

  assign status.idle    = back_idle;
  assign status.q_empty = !q_nonempty;
  assign status.q_full  = q_full;

  tnlc_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk, .rst, .item_valid, .item_stall, .cmd, .name_byte, .last_byte,
    .now_ms, .fill_handle, .status, .q_push, .q_job(q_in), .clear_pending,
    .nb_we, .nb_waddr, .nb_wdata
  );

  tnlc_queue u_queue (
    .clk, .rst, .push(q_push), .din(q_in), .pop(q_pop), .dout(q_out),
    .nonempty(q_nonempty), .full(q_full)
  );

  tnlc_back #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_back (
    .clk, .rst, .lookup_enable, .ttl_ms, .q_nonempty, .q_job(q_out), .q_pop,
    .clear_pending, .idle(back_idle), .meta_we, .meta_waddr, .meta_wdata,
    .meta_raddr, .meta_rdata, .nb_raddr, .nb_rdata, .txt_we, .txt_waddr,
    .txt_wdata, .txt_raddr, .txt_rdata, .result_valid, .result_stall, .hit,
    .handle, .cacheable
  );

  tnlc_ram #(.WIDTH(64), .DEPTH(NB_WORDS)) u_name_ram (
    .clk, .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

  tnlc_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOTS)) u_meta_ram (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  tnlc_ram #(.WIDTH(64), .DEPTH(TXT_D)) u_text_ram (
    .clk, .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
    .raddr(txt_raddr), .rdata(txt_rdata)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ttl_name_lookup_cache_core: names and fills are
// streamed with random idling on both sides, every lookup word is checked
// against an in-bench cache predictor, over several register settings.
// ----------------------------------------------------------------------------
module tb;
  import tnlc_pkg::*;

  localparam int SLOTS    = 4096;
  localparam int KEYB     = 160;
  localparam int WDOG_MAX = 20000;

  typedef struct {
    job_kind_t   kind;
    logic [7:0]  b;
    logic        last;
    logic [31:0] now;
    logic [31:0] fh;
  } word_t;

  typedef struct {
    logic        hit;
    logic [31:0] handle;
    logic        cacheable;
  } answer_t;

  logic        clk = 0, rst = 1;
  logic        cfg_write = 0, cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        item_valid = 0, item_stall, result_valid, result_stall = 0;
  logic        cmd = 0, last_byte = 0;
  logic [7:0]  name_byte = 0;
  logic [31:0] now_ms = 0, fill_handle = 0;
  logic        hit, cacheable;
  logic [31:0] handle;

  ttl_name_lookup_cache_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic        p_enable;
  logic [31:0] p_ttl, p_hash, p_phash;
  int          p_len, p_plen;
  logic        p_long, p_bypass, p_pend;
  logic [7:0]  p_buf[KEYB];
  logic [7:0]  p_win[16];
  logic        c_valid[SLOTS];
  logic [31:0] c_hash[SLOTS], c_handle[SLOTS], c_stamp[SLOTS];
  int          c_len[SLOTS];
  logic [7:0]  c_text[SLOTS][KEYB];

  word_t   send_q[$];
  answer_t answer_q[$];
  int      errors = 0, n_items = 0, n_results = 0, n_hits = 0, n_fills = 0;
  bit      quiet = 0;
  int      wdog = 0;

  function automatic bit win_ends(input logic [127:0] nd, input int n);
    for (int k = 0; k < n; k++)
      if (p_win[16-n+k] != nd[8*n-1-8*k -: 8]) return 0;
    return 1;
  endfunction

  function automatic void name_restart();
    p_hash = FNV_BASIS;
    p_len = 0;
    p_long = 0;
    p_bypass = 0;
    foreach (p_win[i]) p_win[i] = 8'h00;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    if (p_long) return;
    if (p_len >= KEYB - 1) begin
      p_long = 1;
      return;
    end
    p_buf[p_len] = b;
    p_len++;
    p_hash = (p_hash ^ {24'h0, b}) * FNV_PRIME;
    for (int i = 0; i < 15; i++) p_win[i] = p_win[i+1];
    p_win[15] = b | 8'h20;
    if (win_ends(NEEDLE_A, 16) || win_ends({16'h0, NEEDLE_B}, 14)) p_bypass = 1;
  endfunction

  function automatic void cache_predict(input word_t w);
    logic        elig, h;
    logic [11:0] slot;
    answer_t     a;
    if (w.kind == JOB_FILL) begin
      if (p_pend && w.fh != 0) begin
        slot = p_phash[11:0];
        c_valid[slot] = 1;
        c_hash[slot] = p_phash;
        c_handle[slot] = w.fh;
        c_stamp[slot] = w.now;
        c_len[slot] = p_plen;
        for (int i = 0; i < p_plen; i++) c_text[slot][i] = p_buf[i];
        n_fills++;
      end
      p_pend = 0;
      return;
    end
    p_pend = 0;
    if (w.b != 0) absorb_byte(w.b);
    if (!w.last) return;
    elig = !p_long && p_len > 0 && p_hash != 0 && !p_bypass;
    slot = p_hash[11:0];
    h = elig && p_enable && c_valid[slot] && c_hash[slot] == p_hash &&
        (w.now - c_stamp[slot]) < p_ttl && c_len[slot] == p_len;
    if (h)
      for (int i = 0; i < p_len; i++) if (c_text[slot][i] != p_buf[i]) h = 0;
    a.hit = h;
    a.handle = h ? c_handle[slot] : 32'h0;
    p_pend = elig && !h;
    a.cacheable = p_pend;
    p_phash = p_hash;
    p_plen = p_len;
    answer_q.push_back(a);
    name_restart();
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (!rst && (!item_valid || !item_stall)) begin
      if (item_valid) begin
        cache_predict('{job_kind_t'(cmd), name_byte, last_byte, now_ms, fill_handle});
        n_items++;
      end
      if (gap > 0) begin
        gap <= gap - 1;
        item_valid <= 0;
      end else if (send_q.size() > 0 && (quiet || $urandom_range(0, 19) != 0)) begin
        word_t w;
        w = send_q.pop_front();
        item_valid <= 1;
        cmd <= w.kind;
        name_byte <= w.b;
        last_byte <= w.last;
        now_ms <= w.now;
        fill_handle <= w.fh;
      end else begin
        item_valid <= 0;
        if (send_q.size() > 0) gap <= $urandom_range(0, 17);
      end
    end
  end

  // receiver stall and monitor
  int sgap = 0;
  always @(posedge clk) begin
    if (quiet) result_stall <= 0;
    else if (sgap > 0) begin
      sgap <= sgap - 1;
      result_stall <= 1;
    end else if ($urandom_range(0, 15) == 0) begin
      sgap <= $urandom_range(0, 17);
      result_stall <= 1;
    end else result_stall <= 0;

    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (answer_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word hit=%0d handle=%h cacheable=%0d",
                 $time, hit, handle, cacheable);
      end else begin
        answer_t a;
        a = answer_q.pop_front();
        if (hit) n_hits++;
        if (hit !== a.hit) begin
          errors++;
          $display("%0t: hit exp %0d got %0d", $time, a.hit, hit);
        end
        if (handle !== a.handle) begin
          errors++;
          $display("%0t: handle exp %h got %h", $time, a.handle, handle);
        end
        if (cacheable !== a.cacheable) begin
          errors++;
          $display("%0t: cacheable exp %0d got %0d", $time, a.cacheable, cacheable);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // stimulus helpers
  typedef logic [7:0] bytes_t[$];
  bytes_t      pool[16];
  logic [31:0] tnow = 0;

  task automatic push_name(input bytes_t nm);
    for (int i = 0; i < nm.size(); i++)
      send_q.push_back('{JOB_LOOKUP, nm[i], i == nm.size() - 1, tnow, $urandom});
  endtask

  task automatic push_fill(input logic [31:0] fh);
    send_q.push_back('{JOB_FILL, 8'($urandom), 1'($urandom), tnow, fh});
  endtask

  function automatic bytes_t rand_name(input int len, input bit wide);
    bytes_t nm;
    for (int i = 0; i < len; i++)
      nm.push_back(wide ? 8'($urandom) : 8'($urandom_range(8'h41, 8'h7a)));
    if (nm.size() > 0 && nm[nm.size()-1] == 0) nm[nm.size()-1] = 8'h5f;
    return nm;
  endfunction

  // bypass word with random case on each byte
  function automatic bytes_t bypass_name();
    bytes_t       nm;
    logic [127:0] nd;
    int           n;
    if ($urandom_range(0, 1)) begin
      nd = NEEDLE_A;
      n = 16;
    end else begin
      nd = {16'h0, NEEDLE_B};
      n = 14;
    end
    nm = rand_name($urandom_range(0, 4), 0);
    for (int k = 0; k < n; k++)
      nm.push_back(nd[8*n-1-8*k -: 8] ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    nm = {nm, rand_name($urandom_range(0, 3), 0)};
    return nm;
  endfunction

  task automatic cfg_set(input logic idx, input logic [31:0] v);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    if (idx == REG_LOOKUP_ENABLE) p_enable = v[0];
    else p_ttl = v;
  endtask

  task automatic drain();
    while (send_q.size() > 0 || item_valid || answer_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_part(input int count);
    int r, target;
    target = n_items + send_q.size() + count;
    while (send_q.size() + n_items < target) begin
      r = $urandom_range(0, 99);
      tnow = ($urandom_range(0, 49) == 0) ? $urandom : tnow + $urandom_range(0, 250);
      if (r < 60) begin
        push_name(pool[$urandom_range(0, 15)]);
        if ($urandom_range(0, 9) < 8)
          push_fill(($urandom_range(0, 19) == 0) ? 32'h0 : $urandom);
      end else if (r < 68) begin
        push_name(bypass_name());
        push_fill($urandom);
      end else if (r < 70) begin
        push_name(rand_name($urandom_range(157, 166), 1));
        push_fill($urandom);
      end else if (r < 80) push_fill($urandom);
      else begin
        push_name(rand_name($urandom_range(1, 6), 1));
        if ($urandom_range(0, 1)) push_fill($urandom);
      end
    end
  endtask

  initial begin
    logic [31:0] ttls[6];
    logic        ens[6];
    p_enable = 0;
    p_ttl = TTL_RESET;
    p_pend = 0;
    p_phash = 0;
    p_plen = 0;
    name_restart();
    foreach (c_valid[i]) c_valid[i] = 0;
    foreach (pool[i])
      pool[i] = rand_name((i == 15) ? 159 : $urandom_range(1, 24), i >= 12);
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: default registers, then lookups on
    push_name('{8'h00});                     // empty name
    push_name('{8'hff});
    push_fill(32'hffff_ffff);
    push_fill(32'h1234_5678);                // fill with nothing pending
    push_name('{8'h61, 8'h00, 8'h62});       // zero byte inside
    push_fill(32'h0);                        // zero handle drops the miss
    push_name('{8'h7a});
    push_name('{8'h01});                     // byte cancels the pending fill
    push_fill(32'h0000_0001);
    drain();
    cfg_set(REG_LOOKUP_ENABLE, 1);
    cfg_set(REG_TTL_MS, 32'd1000);
    push_name('{8'hff});                     // expected hit
    push_name(bypass_name());
    push_fill(32'h5555_aaaa);
    tnow = 32'd2000;
    push_name('{8'hff});                     // aged out
    push_name('{8'h7a});                     // never stored
    drain();

    ens = '{1, 1, 1, 0, 1, 1};
    ttls = '{32'd1000, 32'd0, 32'hffff_ffff, $urandom, $urandom_range(1, 800), 32'd5000};
    for (int ph = 0; ph < 6; ph++) begin
      cfg_set(REG_LOOKUP_ENABLE, ens[ph]);
      cfg_set(REG_TTL_MS, ttls[ph]);
      if (ph == 5) quiet = 1;
      random_part(240);
      drain();                               // sender holds until all words are back
    end

    $display("tb: %0d items, %0d lookups (%0d hits), %0d stores, 7 register settings",
             n_items, n_results, n_hits, n_fills);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
